// ----- design/sliding_window_average_assert.svh -----
// assertion macros for the sliding window average block
// used by the port checker, no other dependencies
`ifndef SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define SWA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("swa assertion failed");

// next-cycle implication, disabled while rst_n is low
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("swa assertion failed");

`endif

// ----- design/swa_pkg.sv -----
// shared constants for the sliding window average block
// no dependencies
package swa_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WL_W           = 7;
  localparam int AVG_W          = 24;
  localparam int FILL_W         = 7;
  localparam int FRAC_W         = 8;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [WL_W-1:0] WL_RESET = 7'd64;

endpackage

// ----- design/swa_if.sv -----
// handshake channels of the sliding window average block
// depends on swa_pkg
interface swa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [swa_pkg::WL_W-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

interface swa_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [swa_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swa_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [swa_pkg::AVG_W-1:0]  average;
  logic [swa_pkg::FILL_W-1:0]        fill_count;

  modport source (output valid, output average, output fill_count, input ready);
  modport sink   (input valid, input average, input fill_count, output ready);
endinterface

// ----- design/swa_front.sv -----
// front end: window length register, sample ring, running sum and fill count
// depends on swa_pkg and swa_if
module swa_front #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = swa_pkg::SAMPLE_W + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  swa_cfg_if.sink                 cfg_i,
  swa_sample_if.sink              sample_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output logic signed [SUM_W-1:0] push_sum_o,
  output logic [CNT_W-1:0]        push_cnt_o
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LW    = swa_pkg::WL_W + CNT_W;
  localparam int SW    = swa_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_UPDATE = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;

  logic [swa_pkg::WL_W-1:0] wl_q;
  logic [PTR_W-1:0]         wp_q;
  logic [CNT_W-1:0]         held_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     drop_q;
  logic signed [SW-1:0]     smp_q;
  logic signed [SW-1:0]     rd_data_q;
  logic signed [SW-1:0]     ring_q [MAX_WINDOW];

  logic [LW-1:0]    wl_w, held_w, max_w, eff_len;
  logic [CNT_W:0]   oldest;
  logic [PTR_W-1:0] oldest_idx;
  logic             accept, commit, drop_d;
  logic signed [SUM_W-1:0] sub_term, add_term;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == F_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign push_valid_o   = (state_q == F_UPDATE);
  assign commit         = push_valid_o && push_ready_i;

  // clamp the window length to 1..MAX_WINDOW
  always_comb begin
    wl_w   = {{CNT_W{1'b0}}, wl_q};
    held_w = {{swa_pkg::WL_W{1'b0}}, held_q};
    max_w  = LW'(MAX_WINDOW);
    if (wl_w == '0) begin
      eff_len = LW'(1);
    end else if (wl_w > max_w) begin
      eff_len = max_w;
    end else begin
      eff_len = wl_w;
    end
    drop_d = !(held_w < eff_len);
  end

  // slot of the oldest held sample
  always_comb begin
    if ({{(CNT_W + 1 - PTR_W){1'b0}}, wp_q} >= {1'b0, held_q}) begin
      oldest = {{(CNT_W + 1 - PTR_W){1'b0}}, wp_q} - {1'b0, held_q};
    end else begin
      oldest = {{(CNT_W + 1 - PTR_W){1'b0}}, wp_q} + (CNT_W + 1)'(MAX_WINDOW)
               - {1'b0, held_q};
    end
    oldest_idx = oldest[PTR_W-1:0];
  end

  assign sub_term   = drop_q ? {{(SUM_W - SW){rd_data_q[SW-1]}}, rd_data_q} : '0;
  assign add_term   = {{(SUM_W - SW){smp_q[SW-1]}}, smp_q};
  assign push_sum_o = sum_q - sub_term + add_term;
  assign push_cnt_o = drop_q ? held_q : held_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_UPDATE;
      end
      F_UPDATE: begin
        if (commit) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wl_q    <= swa_pkg::WL_RESET;
      wp_q    <= '0;
      held_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) wl_q <= cfg_i.window_length;
      if (commit) begin
        sum_q  <= push_sum_o;
        held_q <= push_cnt_o;
        wp_q   <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
      end
    end
  end

  // ring storage: oldest read at accept, new sample written at commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q     <= sample_i.sample;
      drop_q    <= drop_d;
      rd_data_q <= ring_q[oldest_idx];
    end
    if (commit) ring_q[wp_q] <= smp_q;
  end

endmodule

// ----- design/swa_queue.sv -----
// short fifo between the front end and the divider
// depends on swa_pkg
module swa_queue #(
  parameter int DATA_W = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int DEPTH = swa_pkg::QUEUE_DEPTH;
  localparam int QP_W  = $clog2(DEPTH);
  localparam int QC_W  = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [QP_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QC_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QP_W'(DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QP_W'(DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QC_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- design/swa_divider.sv -----
// back end: restoring divide of sum * 256 by the fill count, one bit a cycle,
// and the result register; depends on swa_pkg and swa_if
module swa_divider #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int CNT_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = swa_pkg::SAMPLE_W + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  logic signed [SUM_W-1:0] pop_sum_i,
  input  logic [CNT_W-1:0]        pop_cnt_i,
  swa_result_if.source            result_o
);

  localparam int DIVD_W = SUM_W + swa_pkg::FRAC_W;
  localparam int CYC_W  = $clog2(DIVD_W);
  localparam int AW     = swa_pkg::AVG_W;
  localparam int FW     = swa_pkg::FILL_W;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_DIV   = 3'b010,
    B_WRITE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [CYC_W-1:0]  cyc_q;
  logic [DIVD_W-1:0] dq_q;
  logic [CNT_W-1:0]  rem_q, div_q;
  logic              neg_q;
  logic              res_valid_q;
  logic [AW-1:0]     avg_q;
  logic [FW-1:0]     fill_q;

  logic              pop, load_out, last;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial, trial_sub;
  logic              ge;
  logic [DIVD_W-1:0] quot;
  logic [CNT_W+FW-1:0] cnt_wide;

  assign pop_ready_o = (state_q == B_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign last        = (cyc_q == CYC_W'(DIVD_W - 1));
  assign load_out    = (state_q == B_WRITE) && (!res_valid_q || result_o.ready);

  assign mag = pop_sum_i[SUM_W-1] ? (~pop_sum_i) + SUM_W'(1) : pop_sum_i;

  // one restoring step
  assign trial     = {rem_q, dq_q[DIVD_W-1]};
  assign ge        = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};

  assign quot     = neg_q ? (~dq_q) + DIVD_W'(1) : dq_q;
  assign cnt_wide = {{FW{1'b0}}, div_q};

  assign result_o.valid      = res_valid_q;
  assign result_o.average    = avg_q;
  assign result_o.fill_count = fill_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop) state_d = B_DIV;
      end
      B_DIV: begin
        if (last) state_d = B_WRITE;
      end
      B_WRITE: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cyc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cyc_q <= '0;
      end else if (state_q == B_DIV) begin
        cyc_q <= cyc_q + CYC_W'(1);
      end
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      dq_q  <= {mag, {swa_pkg::FRAC_W{1'b0}}};
      rem_q <= '0;
      div_q <= pop_cnt_i;
      neg_q <= pop_sum_i[SUM_W-1];
    end else if (state_q == B_DIV) begin
      dq_q  <= {dq_q[DIVD_W-2:0], ge};
      rem_q <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (load_out) begin
      avg_q  <= quot[AW-1:0];
      fill_q <= cnt_wide[FW-1:0];
    end
  end

endmodule

// ----- design/sliding_window_average.sv -----
// sliding window average, top level
// depends on swa_pkg, swa_if, swa_front, swa_queue, swa_divider
//
//   port       dir   carries
//   cfg_i      in    window_length, write only, always ready
//   sample_i   in    one signed 16-bit sample per item
//   result_o   out   average (s.8 fixed point) and fill_count per item
//
// the front end reads the ring, then updates the sum; it takes no new sample until the queue takes the item
// the divider works out one quotient bit per cycle and takes no new item until its
// result is written to the result register; it sets the sustained rate
// a 2-entry queue and the result register let either side stall alone
// reset clears counts and the sum; ring contents are only read once written
module sliding_window_average #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swa_cfg_if.sink       cfg_i,
  swa_sample_if.sink    sample_i,
  swa_result_if.source  result_o
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = swa_pkg::SAMPLE_W + CNT_W;
  localparam int Q_W   = SUM_W + CNT_W;

  logic                    f_valid, f_ready, d_valid, d_ready;
  logic signed [SUM_W-1:0] f_sum, d_sum;
  logic [CNT_W-1:0]        f_cnt, d_cnt;
  logic [Q_W-1:0]          q_out;

  swa_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .sample_i     (sample_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_sum_o   (f_sum),
    .push_cnt_o   (f_cnt)
  );

  swa_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_sum, f_cnt}),
    .pop_valid_o  (d_valid),
    .pop_ready_i  (d_ready),
    .pop_data_o   (q_out)
  );

  assign d_sum = q_out[Q_W-1:CNT_W];
  assign d_cnt = q_out[CNT_W-1:0];

  swa_divider #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (d_valid),
    .pop_ready_o (d_ready),
    .pop_sum_i   (d_sum),
    .pop_cnt_i   (d_cnt),
    .result_o    (result_o)
  );

endmodule

// ----- design/swa_checker.sv -----
// port-level checks for the sliding window average block, bound to the top
// depends on sliding_window_average_assert.svh and swa_pkg
`include "sliding_window_average_assert.svh"

module swa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_ready,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [swa_pkg::AVG_W-1:0]  average
);

  // a stalled result keeps its value
  `SWA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(average))

  // front end holds sample ready low after each accepted item while it updates the sum
  `SWA_ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // mean never exceeds the largest sample times 256
  `SWA_ASSERT_SAME(a_avg_range, clk_i, rst_ni, out_valid, average[23] || (average[22:0] <= 23'h7fff00))

  // result register is cleared and cfg stays ready while in reset
  `SWA_ASSERT_SAME(a_rst_idle, clk_i, 1'b1, !rst_ni, !out_valid && cfg_ready)

endmodule

bind sliding_window_average swa_checker u_swa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .cfg_ready (cfg_i.ready),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .average   (result_o.average)
);
